/* rtl/pmc_pkg.sv */
package pmc_pkg;

  // Field widths (Q12.12 coordinates, exact Q26.24 projection)
  localparam int unsigned COORD_W    = 24;
  localparam int unsigned NUM_COORDS = 4;
  localparam int unsigned LANE_W     = 2 * COORD_W;
  localparam int unsigned PROJ_W     = 50;
  localparam int unsigned SPLIT_W    = 25;
  localparam int unsigned PROD_W     = PROJ_W + COORD_W;
  localparam int unsigned DIM_W      = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = COORD_W;

  localparam logic [DIM_W-1:0] DIM_RESET = 3'd3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIM_COUNT = 3'd0,
    CFG_RATIONAL  = 3'd1,
    CFG_DIR_0     = 3'd2,
    CFG_DIR_1     = 3'd3,
    CFG_DIR_2     = 3'd4,
    CFG_DIR_3     = 3'd5
  } pmc_cfg_idx_e;

  // Verdict codes
  typedef enum logic [1:0] {
    CAUSE_NONE     = 2'd0,
    CAUSE_DECREASE = 2'd1,
    CAUSE_WEIGHT   = 2'd2
  } pmc_cause_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_0;
    logic signed [COORD_W-1:0] coord_1;
    logic signed [COORD_W-1:0] coord_2;
    logic signed [COORD_W-1:0] coord_3;
    logic signed [COORD_W-1:0] weight;
    logic                      last_point;
  } pmc_in_t;

  typedef struct packed {
    logic       monotone;
    logic [1:0] fail_cause;
  } pmc_out_t;

  // One classified point handed from front to back
  typedef struct packed {
    logic signed [PROJ_W-1:0]  proj;
    logic signed [COORD_W-1:0] weight;
    logic                      rational;
    logic                      last_point;
  } pmc_item_t;

endpackage

/* rtl/pmc_fifo.sv */
module pmc_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  pmc_pkg::pmc_item_t            push_data_i,
  input  logic                          pop_i,
  output logic                          valid_o,
  output pmc_pkg::pmc_item_t            head_o,
  output logic [$clog2(DEPTH+1)-1:0]    count_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH+1);

  pmc_pkg::pmc_item_t mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < CNT_W'(DEPTH)))
    else $error("fifo push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("fifo pop while empty");

endmodule

/* rtl/pmc_front.sv */
module pmc_front #(
  parameter int unsigned MAX_DIM = 4,
  parameter int unsigned DEPTH   = 4
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  pmc_pkg::pmc_in_t                       in_data_i,
  input  logic                                   cfg_we_i,
  input  logic [pmc_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [pmc_pkg::CFG_DATA_W-1:0]         cfg_wdata_i,
  input  logic [$clog2(DEPTH+1)-1:0]             fifo_count_i,
  output logic                                   push_o,
  output pmc_pkg::pmc_item_t                     push_data_o
);

  localparam int unsigned NUM_LANES =
    (MAX_DIM < pmc_pkg::NUM_COORDS) ? MAX_DIM : pmc_pkg::NUM_COORDS;
  localparam int unsigned CNT_W = $clog2(DEPTH+1);
  localparam int unsigned OCC_W = CNT_W + 1;

  // Configuration registers
  logic [pmc_pkg::DIM_W-1:0]          dim_q;
  logic                               rat_q;
  logic signed [pmc_pkg::COORD_W-1:0] dir_q [pmc_pkg::NUM_COORDS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= pmc_pkg::DIM_RESET;
      rat_q <= 1'b0;
      for (int i = 0; i < pmc_pkg::NUM_COORDS; i++) begin
        dir_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pmc_pkg::CFG_DIM_COUNT: dim_q    <= cfg_wdata_i[pmc_pkg::DIM_W-1:0];
        pmc_pkg::CFG_RATIONAL:  rat_q    <= cfg_wdata_i[0];
        pmc_pkg::CFG_DIR_0:     dir_q[0] <= cfg_wdata_i;
        pmc_pkg::CFG_DIR_1:     dir_q[1] <= cfg_wdata_i;
        pmc_pkg::CFG_DIR_2:     dir_q[2] <= cfg_wdata_i;
        pmc_pkg::CFG_DIR_3:     dir_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Accept only when the queue has room for everything in flight
  logic             s1_valid_q;
  logic             s2_valid_q;
  logic [OCC_W-1:0] occupancy;
  logic             accept;

  assign occupancy = OCC_W'(fifo_count_i) + OCC_W'(s1_valid_q) + OCC_W'(s2_valid_q);
  assign in_stall_o = (occupancy >= OCC_W'(DEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  // Stage 1: one multiplier per lane, lanes past dim_count give zero
  logic signed [pmc_pkg::COORD_W-1:0] coord [pmc_pkg::NUM_COORDS];
  logic signed [pmc_pkg::LANE_W-1:0]  lane_raw [NUM_LANES];
  logic signed [pmc_pkg::LANE_W-1:0]  s1_prod_q [NUM_LANES];
  logic signed [pmc_pkg::COORD_W-1:0] s1_weight_q;
  logic                               s1_rat_q;
  logic                               s1_last_q;

  assign coord[0] = in_data_i.coord_0;
  assign coord[1] = in_data_i.coord_1;
  assign coord[2] = in_data_i.coord_2;
  assign coord[3] = in_data_i.coord_3;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    assign lane_raw[g] = coord[g] * dir_q[g];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        s1_prod_q[i] <= (dim_q > pmc_pkg::DIM_W'(i)) ? lane_raw[i] : '0;
      end
      s1_weight_q <= in_data_i.weight;
      s1_rat_q    <= rat_q;
      s1_last_q   <= in_data_i.last_point;
    end
  end

  // Stage 2: sum of lanes, wraps to the projection width
  logic signed [pmc_pkg::PROJ_W-1:0] sum;
  pmc_pkg::pmc_item_t                s2_q;

  always_comb begin
    sum = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      sum = sum + pmc_pkg::PROJ_W'(s1_prod_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_q.proj       <= sum;
      s2_q.weight     <= s1_weight_q;
      s2_q.rational   <= s1_rat_q;
      s2_q.last_point <= s1_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
    end
  end

  assign push_o      = s2_valid_q;
  assign push_data_o = s2_q;

endmodule

/* rtl/pmc_back.sv */
module pmc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  pmc_pkg::pmc_item_t head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pmc_pkg::pmc_out_t  out_data_o
);

  localparam int unsigned PROJ_W  = pmc_pkg::PROJ_W;
  localparam int unsigned COORD_W = pmc_pkg::COORD_W;
  localparam int unsigned SPLIT_W = pmc_pkg::SPLIT_W;
  localparam int unsigned PROD_W  = pmc_pkg::PROD_W;
  localparam int unsigned LO_W    = SPLIT_W + 1 + COORD_W;
  localparam int unsigned HI_W    = PROJ_W - SPLIT_W + COORD_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HI,
    ST_SUM,
    ST_CMP
  } state_e;

  state_e                      state_q, state_d;
  pmc_pkg::pmc_item_t          cur_q, cur_d;
  logic signed [LO_W-1:0]      lo_a_q, lo_a_d, lo_b_q, lo_b_d;
  logic signed [HI_W-1:0]      hi_a_q, hi_a_d, hi_b_q, hi_b_d;
  logic signed [PROD_W-1:0]    prod_a_q, prod_a_d, prod_b_q, prod_b_d;

  // Polyline state
  logic signed [PROJ_W-1:0]    prev_p_q, prev_p_d;
  logic signed [COORD_W-1:0]   prev_w_q, prev_w_d;
  logic                        wneg_q, wneg_d;
  pmc_pkg::pmc_cause_e         cause_q, cause_d;
  logic                        at_start_q, at_start_d;

  logic                        out_valid_q, out_valid_d;
  pmc_pkg::pmc_out_t           out_q, out_d;

  // Commit control
  logic                        head_mul;
  logic                        out_free;
  pmc_pkg::pmc_item_t          sel;
  logic                        can_commit;
  logic                        commit;
  logic                        cmp_lt;

  // Rational point that needs the cross-multiplied compare
  assign head_mul = head_i.rational && !at_start_q && (cause_q == pmc_pkg::CAUSE_NONE) &&
                    (head_i.weight != '0) && (head_i.weight[COORD_W-1] == wneg_q);

  assign out_free   = !out_valid_q || !out_stall_i;
  assign sel        = (state_q == ST_CMP) ? cur_q : head_i;
  assign can_commit = !sel.last_point || out_free;
  assign commit     = ((state_q == ST_IDLE) && head_valid_i && !head_mul && can_commit) ||
                      ((state_q == ST_CMP) && can_commit);
  assign pop_o      = (state_q == ST_IDLE) && head_valid_i && (head_mul || can_commit);
  assign cmp_lt     = (state_q == ST_CMP) && ($signed(prod_a_q) < $signed(prod_b_q));

  // Sequencer for the split products p*w_prev and p_prev*w
  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    lo_a_d   = lo_a_q;
    lo_b_d   = lo_b_q;
    hi_a_d   = hi_a_q;
    hi_b_d   = hi_b_q;
    prod_a_d = prod_a_q;
    prod_b_d = prod_b_q;
    unique case (state_q)
      ST_IDLE: begin
        if (head_valid_i && head_mul) begin
          cur_d   = head_i;
          lo_a_d  = $signed({1'b0, head_i.proj[SPLIT_W-1:0]}) * $signed(prev_w_q);
          lo_b_d  = $signed({1'b0, prev_p_q[SPLIT_W-1:0]}) * $signed(head_i.weight);
          state_d = ST_HI;
        end
      end
      ST_HI: begin
        hi_a_d  = $signed(cur_q.proj[PROJ_W-1:SPLIT_W]) * $signed(prev_w_q);
        hi_b_d  = $signed(prev_p_q[PROJ_W-1:SPLIT_W]) * $signed(cur_q.weight);
        state_d = ST_SUM;
      end
      ST_SUM: begin
        prod_a_d = (PROD_W'(hi_a_q) <<< SPLIT_W) + PROD_W'(lo_a_q);
        prod_b_d = (PROD_W'(hi_b_q) <<< SPLIT_W) + PROD_W'(lo_b_q);
        state_d  = ST_CMP;
      end
      ST_CMP: begin
        if (can_commit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State update and verdict on commit
  always_comb begin
    pmc_pkg::pmc_cause_e cause_new;
    logic                w_zero;
    logic                w_neg;
    w_zero      = (sel.weight == '0);
    w_neg       = sel.weight[COORD_W-1];
    cause_new   = cause_q;
    prev_p_d    = prev_p_q;
    prev_w_d    = prev_w_q;
    wneg_d      = wneg_q;
    cause_d     = cause_q;
    at_start_d  = at_start_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (commit) begin
      if (at_start_q) begin
        cause_new  = (sel.rational && w_zero) ? pmc_pkg::CAUSE_WEIGHT : pmc_pkg::CAUSE_NONE;
        wneg_d     = sel.rational && w_neg;
        prev_w_d   = sel.rational ? sel.weight : '0;
        prev_p_d   = sel.proj;
        at_start_d = 1'b0;
      end else if (cause_q == pmc_pkg::CAUSE_NONE) begin
        if (sel.rational) begin
          if (w_zero || (w_neg != wneg_q)) begin
            cause_new = pmc_pkg::CAUSE_WEIGHT;
          end else if (cmp_lt) begin
            cause_new = pmc_pkg::CAUSE_DECREASE;
          end
          prev_w_d = sel.weight;
        end else begin
          if ($signed(sel.proj) < $signed(prev_p_q)) begin
            cause_new = pmc_pkg::CAUSE_DECREASE;
          end
          prev_w_d = '0;
          wneg_d   = 1'b0;
        end
        prev_p_d = sel.proj;
      end
      cause_d = cause_new;
      // Verdict on the last point, then start a new polyline
      if (sel.last_point) begin
        out_valid_d      = 1'b1;
        out_d.monotone   = (cause_new == pmc_pkg::CAUSE_NONE);
        out_d.fail_cause = cause_new;
        at_start_d       = 1'b1;
        cause_d          = pmc_pkg::CAUSE_NONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_p_q    <= '0;
      prev_w_q    <= '0;
      wneg_q      <= 1'b0;
      cause_q     <= pmc_pkg::CAUSE_NONE;
      at_start_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_p_q    <= prev_p_d;
      prev_w_q    <= prev_w_d;
      wneg_q      <= wneg_d;
      cause_q     <= cause_d;
      at_start_q  <= at_start_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    lo_a_q   <= lo_a_d;
    lo_b_q   <= lo_b_d;
    hi_a_q   <= hi_a_d;
    hi_b_q   <= hi_b_d;
    prod_a_q <= prod_a_d;
    prod_b_q <= prod_b_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_verdict_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.monotone == (out_q.fail_cause == pmc_pkg::CAUSE_NONE)))
    else $error("monotone flag disagrees with fail cause");

  a_start_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    at_start_q |-> (cause_q == pmc_pkg::CAUSE_NONE))
    else $error("failure carried into a new polyline");

endmodule

/* rtl/polyline_projection_monotonicity_check_core.sv */
// Throughput: 1 point per cycle unless the queue is out of room, a last point waits on a
// stalled output, or a point needs the product compare; such a point (rational, valid
// weight, no earlier failure, not first of its polyline) holds the back in ST_HI to ST_CMP.
// Reset clears the configuration to its defaults, empties the queue and starts a new
// polyline; results wait in an output register while new points are taken.
module polyline_projection_monotonicity_check_core #(
  parameter int unsigned MAX_DIM = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  pmc_pkg::pmc_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output pmc_pkg::pmc_out_t               out_data_o,
  input  logic                            cfg_we_i,
  input  logic [pmc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pmc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH+1);

  logic               push;
  pmc_pkg::pmc_item_t push_data;
  logic               pop;
  logic               head_valid;
  pmc_pkg::pmc_item_t head;
  logic [CNT_W-1:0]   fifo_count;

  // Front: config, dot product, projection
  pmc_front #(
    .MAX_DIM (MAX_DIM),
    .DEPTH   (FIFO_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fifo_count_i (fifo_count),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  // Queue between front and back
  pmc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .valid_o     (head_valid),
    .head_o      (head),
    .count_o     (fifo_count)
  );

  // Back: monotonicity and weight checks, verdict
  pmc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

/* bench/pmc_verdict_checker.sv */
module pmc_verdict_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  pmc_pkg::pmc_in_t               in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  pmc_pkg::pmc_out_t              out_data_i,
  input  logic                           cfg_we_i,
  input  logic [pmc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pmc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int unsigned                    mismatch_count_o,
  output int unsigned                    verdicts_owed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the configuration registers
  logic [pmc_pkg::DIM_W-1:0]          dim_q;
  logic                               rational_q;
  logic signed [pmc_pkg::COORD_W-1:0] dir_q [pmc_pkg::NUM_COORDS];

  // Running state of the polyline being checked
  logic signed [pmc_pkg::PROJ_W-1:0]  last_proj;
  logic signed [pmc_pkg::COORD_W-1:0] last_weight;
  logic                               weight_neg;
  pmc_pkg::pmc_cause_e                cause_q;
  logic                               fresh;

  pmc_pkg::pmc_out_t verdict_q [$];
  pmc_pkg::pmc_out_t want;

  // Exact dot product over the active coordinates, wrapped to the projection width
  function automatic logic signed [pmc_pkg::PROJ_W-1:0] project_point(
    input pmc_pkg::pmc_in_t pt);
    logic signed [63:0]                 acc;
    logic signed [pmc_pkg::COORD_W-1:0] c [pmc_pkg::NUM_COORDS];
    int unsigned                        n;
    c[0] = pt.coord_0;
    c[1] = pt.coord_1;
    c[2] = pt.coord_2;
    c[3] = pt.coord_3;
    n = (dim_q > pmc_pkg::NUM_COORDS) ? pmc_pkg::NUM_COORDS : dim_q;
    acc = '0;
    for (int i = 0; i < int'(n); i++) begin
      acc += c[i] * dir_q[i];
    end
    return acc[pmc_pkg::PROJ_W-1:0];
  endfunction

  // x*wx < y*wy, full precision
  function automatic logic quotient_below(input logic signed [pmc_pkg::PROJ_W-1:0]  x,
                                          input logic signed [pmc_pkg::COORD_W-1:0] wx,
                                          input logic signed [pmc_pkg::PROJ_W-1:0]  y,
                                          input logic signed [pmc_pkg::COORD_W-1:0] wy);
    logic signed [127:0] lhs, rhs;
    lhs = x;
    lhs = lhs * wx;
    rhs = y;
    rhs = rhs * wy;
    return lhs < rhs;
  endfunction

  // Fold one accepted point into the polyline state; queue a verdict on the last one
  function automatic void advance_polyline(input pmc_pkg::pmc_in_t pt);
    logic signed [pmc_pkg::PROJ_W-1:0]  p;
    logic signed [pmc_pkg::COORD_W-1:0] w;
    pmc_pkg::pmc_out_t                  v;
    p = project_point(pt);
    w = pt.weight;
    if (fresh) begin
      cause_q = pmc_pkg::CAUSE_NONE;
      if (rational_q && w == 0) cause_q = pmc_pkg::CAUSE_WEIGHT;
      weight_neg  = rational_q && (w < 0);
      last_weight = rational_q ? w : '0;
      last_proj   = p;
      fresh       = 1'b0;
    end else if (cause_q == pmc_pkg::CAUSE_NONE) begin
      if (rational_q) begin
        if (w == 0 || (w < 0) != weight_neg) begin
          cause_q = pmc_pkg::CAUSE_WEIGHT;
        end else if (quotient_below(p, last_weight, last_proj, w)) begin
          cause_q = pmc_pkg::CAUSE_DECREASE;
        end
        last_weight = w;
      end else begin
        if (p < last_proj) cause_q = pmc_pkg::CAUSE_DECREASE;
        last_weight = '0;
        weight_neg  = 1'b0;
      end
      last_proj = p;
    end
    if (pt.last_point) begin
      v.monotone   = (cause_q == pmc_pkg::CAUSE_NONE);
      v.fail_cause = cause_q;
      verdict_q.push_back(v);
      fresh   = 1'b1;
      cause_q = pmc_pkg::CAUSE_NONE;
    end
  endfunction

  // Watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q            = pmc_pkg::DIM_RESET;
      rational_q       = 1'b0;
      for (int i = 0; i < pmc_pkg::NUM_COORDS; i++) dir_q[i] = '0;
      last_proj        = '0;
      last_weight      = '0;
      weight_neg       = 1'b0;
      cause_q          = pmc_pkg::CAUSE_NONE;
      fresh            = 1'b1;
      verdict_q.delete();
      mismatch_count_o = 0;
      verdicts_owed_o  = 0;
    end else begin
      if (in_valid_i && !in_stall_i) advance_polyline(in_data_i);

      if (out_valid_i && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          $error("verdict beat with none pending: monotone=%0b fail_cause=%0d",
                 out_data_i.monotone, out_data_i.fail_cause);
          mismatch_count_o++;
        end else begin
          want = verdict_q.pop_front();
          if (out_data_i.monotone !== want.monotone) begin
            $error("monotone: expected %0b, got %0b", want.monotone, out_data_i.monotone);
            mismatch_count_o++;
          end
          if (out_data_i.fail_cause !== want.fail_cause) begin
            $error("fail_cause: expected %0d, got %0d",
                   want.fail_cause, out_data_i.fail_cause);
            mismatch_count_o++;
          end
        end
      end

      // writes take effect from the next point on
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pmc_pkg::CFG_DIM_COUNT: dim_q      = cfg_wdata_i[pmc_pkg::DIM_W-1:0];
          pmc_pkg::CFG_RATIONAL:  rational_q = cfg_wdata_i[0];
          pmc_pkg::CFG_DIR_0:     dir_q[0]   = cfg_wdata_i;
          pmc_pkg::CFG_DIR_1:     dir_q[1]   = cfg_wdata_i;
          pmc_pkg::CFG_DIR_2:     dir_q[2]   = cfg_wdata_i;
          pmc_pkg::CFG_DIR_3:     dir_q[3]   = cfg_wdata_i;
          default: ;
        endcase
      end

      verdicts_owed_o = verdict_q.size();
    end
  end

endmodule

/* bench/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CMAX        = 8388607;
  localparam int          CMIN        = -8388608;
  localparam int          ONE         = 4096;        // 1.0 in Q12.12
  localparam int unsigned SETTLE      = 24;          // lets the pipe empty after the last verdict
  localparam int unsigned LONG_HOLD   = 600;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  pmc_pkg::pmc_in_t               in_data;
  logic                           out_valid;
  logic                           out_stall;
  pmc_pkg::pmc_out_t              out_data;
  logic                           cfg_we;
  logic [pmc_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [pmc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  int unsigned mismatch_count;
  int unsigned verdicts_owed;

  // Stimulus-side copy of the setup, used only to shape the points
  logic                               cur_rat;
  logic signed [pmc_pkg::COORD_W-1:0] cur_dir [pmc_pkg::NUM_COORDS];
  int unsigned                        burst_left;
  int unsigned                        hold_asked;
  int unsigned                        hold_served;

  polyline_projection_monotonicity_check_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  pmc_verdict_checker verdict_chk (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_count_o (mismatch_count),
    .verdicts_owed_o  (verdicts_owed)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // Receiver: stall pattern in segments, plus long hold-offs on request
  initial begin : receiver
    int unsigned span, pct;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_served != hold_asked) begin
        for (int j = 0; j < LONG_HOLD; j++) begin
          @(posedge clk);
          out_stall <= 1'b1;
        end
        hold_served++;
      end else begin
        span = $urandom_range(10, 120);
        case ($urandom_range(4))
          0, 1:    pct = 0;
          2:       pct = 25;
          3:       pct = 50;
          default: pct = 85;
        endcase
        for (int j = 0; j < int'(span); j++) begin
          @(posedge clk);
          out_stall <= ($urandom_range(99) < pct);
        end
      end
    end
  end

  function automatic pmc_pkg::pmc_in_t mk_point(input int c0, input int c1, input int c2,
                                                input int c3, input int w, input logic last);
    pmc_pkg::pmc_in_t pt;
    pt.coord_0    = pmc_pkg::COORD_W'(c0);
    pt.coord_1    = pmc_pkg::COORD_W'(c1);
    pt.coord_2    = pmc_pkg::COORD_W'(c2);
    pt.coord_3    = pmc_pkg::COORD_W'(c3);
    pt.weight     = pmc_pkg::COORD_W'(w);
    pt.last_point = last;
    return pt;
  endfunction

  function automatic logic signed [pmc_pkg::COORD_W-1:0] pick_dir();
    case ($urandom_range(5))
      0:       return '0;
      1:       return pmc_pkg::COORD_W'(CMAX);
      2:       return pmc_pkg::COORD_W'(CMIN);
      3:       return pmc_pkg::COORD_W'($urandom_range(16384) - 8192);
      default: return pmc_pkg::COORD_W'($urandom());
    endcase
  endfunction

  // One beat on the point channel, with bursts and gaps
  task automatic send_point(input pmc_pkg::pmc_in_t pt);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 40);
      if ($urandom_range(3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= pt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop sending until every verdict is back and the pipe is empty
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (verdicts_owed != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input pmc_pkg::pmc_cfg_idx_e idx,
                           input logic [pmc_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Program all registers; unused high bits of the narrow ones carry junk
  task automatic set_mode(input logic [pmc_pkg::DIM_W-1:0] dim, input logic rat,
                          input int d0, input int d1, input int d2, input int d3);
    logic [pmc_pkg::CFG_DATA_W-1:0] word;
    cur_rat    = rat;
    cur_dir[0] = pmc_pkg::COORD_W'(d0);
    cur_dir[1] = pmc_pkg::COORD_W'(d1);
    cur_dir[2] = pmc_pkg::COORD_W'(d2);
    cur_dir[3] = pmc_pkg::COORD_W'(d3);
    word = pmc_pkg::CFG_DATA_W'($urandom());
    word[pmc_pkg::DIM_W-1:0] = dim;
    cfg_write(pmc_pkg::CFG_DIM_COUNT, word);
    word = pmc_pkg::CFG_DATA_W'($urandom());
    word[0] = rat;
    cfg_write(pmc_pkg::CFG_RATIONAL, word);
    cfg_write(pmc_pkg::CFG_DIR_0, pmc_pkg::CFG_DATA_W'(d0));
    cfg_write(pmc_pkg::CFG_DIR_1, pmc_pkg::CFG_DATA_W'(d1));
    cfg_write(pmc_pkg::CFG_DIR_2, pmc_pkg::CFG_DATA_W'(d2));
    cfg_write(pmc_pkg::CFG_DIR_3, pmc_pkg::CFG_DATA_W'(d3));
  endtask

  // Random polylines: mostly monotone ramps along the direction, some broken
  task automatic stream_points(input int unsigned budget);
    int unsigned                        n, len, kind, flip_at;
    logic                               up;
    pmc_pkg::pmc_in_t                   pt;
    logic signed [pmc_pkg::COORD_W-1:0] base  [pmc_pkg::NUM_COORDS];
    logic signed [pmc_pkg::COORD_W-1:0] slope [pmc_pkg::NUM_COORDS];
    logic signed [pmc_pkg::COORD_W-1:0] c     [pmc_pkg::NUM_COORDS];
    logic signed [pmc_pkg::COORD_W-1:0] w0, w;
    n = 0;
    while (n < budget) begin
      len     = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      kind    = $urandom_range(99);
      flip_at = $urandom_range(len - 1);
      w0      = pmc_pkg::COORD_W'($urandom_range(1, 1 << 20));
      if ($urandom_range(1)) w0 = -w0;
      for (int i = 0; i < pmc_pkg::NUM_COORDS; i++) begin
        base[i]  = pmc_pkg::COORD_W'($urandom_range(1 << 21) - (1 << 20));
        up       = (cur_dir[i] == 0) ? 1'($urandom_range(1)) : (cur_dir[i] > 0);
        // a negative weight turns the quotient around
        if (cur_rat && w0 < 0) up = !up;
        slope[i] = pmc_pkg::COORD_W'($urandom_range(4095));
        if (!up) slope[i] = -slope[i];
      end
      for (int k = 0; k < int'(len); k++) begin
        for (int i = 0; i < pmc_pkg::NUM_COORDS; i++) begin
          if (kind < 15 && k == int'(flip_at) && k != 0)
            c[i] = pmc_pkg::COORD_W'(base[i] - k * slope[i]);
          else if (kind < 50)
            c[i] = pmc_pkg::COORD_W'(base[i] + k * slope[i]);
          else if (kind < 75)
            c[i] = pmc_pkg::COORD_W'(base[i] + $urandom_range(32767) - 16384);
          else if (kind < 90)
            c[i] = pmc_pkg::COORD_W'($urandom());
          else
            c[i] = pmc_pkg::COORD_W'(base[i] + k * slope[i]);
        end
        w = w0;
        if (kind >= 50 && kind < 75) begin
          w = pmc_pkg::COORD_W'($urandom_range(1, CMAX));
          if (w0 < 0) w = -w;
        end else if (kind >= 75 && kind < 90) begin
          w = pmc_pkg::COORD_W'($urandom());
        end else if (kind >= 90 && k == int'(flip_at)) begin
          w = $urandom_range(1) ? '0 : -w0;
        end
        pt.coord_0    = c[0];
        pt.coord_1    = c[1];
        pt.coord_2    = c[2];
        pt.coord_3    = c[3];
        pt.weight     = w;
        pt.last_point = (k == int'(len) - 1);
        // sometimes leave the polyline open across the next setup change
        if (pt.last_point && n + 1 >= budget && $urandom_range(1)) pt.last_point = 1'b0;
        send_point(pt);
        n++;
      end
    end
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    logic [pmc_pkg::DIM_W-1:0] dim;
    logic                      rat;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_wdata   = '0;
    burst_left  = 0;
    hold_asked  = 0;
    hold_served = 0;
    cur_rat     = 1'b0;
    for (int i = 0; i < pmc_pkg::NUM_COORDS; i++) cur_dir[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // plain, full dimension, extreme directions
    set_mode(3'd4, 1'b0, CMAX, CMIN, 1, -ONE);
    send_point(mk_point(CMAX, CMAX, CMAX, CMAX, CMAX, 1'b1));   // lone point
    send_point(mk_point(CMIN, CMIN, CMIN, CMIN, CMIN, 1'b0));
    send_point(mk_point(CMAX, CMIN, CMAX, CMIN, 0, 1'b0));
    send_point(mk_point(CMIN, CMAX, CMIN, CMAX, 0, 1'b1));
    // equal projections pass
    send_point(mk_point(ONE, 2 * ONE, 3 * ONE, 4 * ONE, 0, 1'b0));
    send_point(mk_point(ONE, 2 * ONE, 3 * ONE, 4 * ONE, 0, 1'b1));
    // a drop, then a rise that must not clear it
    send_point(mk_point(0, 0, 0, 0, 0, 1'b0));
    send_point(mk_point(0, ONE, 0, 0, 0, 1'b0));
    send_point(mk_point(CMAX, 0, 0, 0, 0, 1'b1));
    drain_results();

    // empty dot product
    set_mode(3'd0, 1'b0, CMAX, CMAX, CMAX, CMAX);
    send_point(mk_point(CMAX, CMAX, CMAX, CMAX, 0, 1'b0));
    send_point(mk_point(CMIN, CMIN, CMIN, CMIN, 0, 1'b1));
    drain_results();

    // dimension above the limit, weighted points
    set_mode(3'd7, 1'b1, ONE, 0, 0, ONE);
    send_point(mk_point(ONE, 0, 0, ONE, 0, 1'b1));               // zero first weight
    send_point(mk_point(ONE, 0, 0, 0, 0, 1'b0));
    send_point(mk_point(2 * ONE, 0, 0, 0, ONE, 1'b1));
    send_point(mk_point(ONE, 0, 0, 0, -ONE, 1'b0));              // negative sign kept
    send_point(mk_point(ONE, 0, 0, 0, -2 * ONE, 1'b0));
    send_point(mk_point(ONE, 0, 0, 0, ONE, 1'b1));               // then flips
    send_point(mk_point(CMAX, CMAX, CMAX, CMAX, CMAX, 1'b0));
    send_point(mk_point(CMIN, CMIN, CMIN, CMIN, CMIN, 1'b1));
    // same projection, larger weight: quotient drops
    send_point(mk_point(ONE, 0, 0, 0, ONE, 1'b0));
    send_point(mk_point(ONE, 0, 0, 0, 2 * ONE, 1'b1));
    // mode switched inside one polyline
    send_point(mk_point(ONE, 0, 0, ONE, ONE, 1'b0));
    drain_results();
    set_mode(3'd4, 1'b0, ONE, 0, 0, ONE);
    send_point(mk_point(2 * ONE, 0, 0, 0, -ONE, 1'b0));
    drain_results();
    set_mode(3'd4, 1'b1, ONE, 0, 0, ONE);
    send_point(mk_point(3 * ONE, 0, 0, 0, ONE, 1'b1));

    // random phases, each under a fresh setup
    for (int unsigned phase = 0; phase < 8; phase++) begin
      drain_results();
      dim = ($urandom_range(99) < 80) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(7));
      rat = (phase < 4) ? phase[0] : 1'($urandom_range(1));
      set_mode(dim, rat, pick_dir(), pick_dir(), pick_dir(), pick_dir());
      if (phase == 0 || phase == 3) hold_asked++;
      stream_points(235);
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* polyline_projection_monotonicity_check_core.f */
rtl/pmc_pkg.sv
rtl/pmc_fifo.sv
rtl/pmc_front.sv
rtl/pmc_back.sv
rtl/polyline_projection_monotonicity_check_core.sv
bench/pmc_verdict_checker.sv
bench/testbench.sv
